FILE: src/ndpr_pkg.sv
// Shared types and constants for the N-d pad/reorder address generator.
// No dependencies; used by the core and its port checker.
`default_nettype none

package ndpr_pkg;

  localparam int OFF_W    = 35;   // byte offset width
  localparam int CFG_W    = 64;   // widest config register
  localparam int NAX_W    = 3;    // num_axes register width
  localparam int EB_W     = 4;    // element_bytes register width
  localparam int FILL_W   = 64;
  localparam int MAX_EB   = 8;    // element size ceiling in bytes
  localparam int CIDX_W   = 3;
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 136;  // 35 + 35 + 64, rounded up to bytes
  localparam int M_USER_W = 1;

  // tdata field positions on the master side
  localparam int WOFF_LO = 0;
  localparam int ROFF_LO = WOFF_LO + OFF_W;
  localparam int FILL_LO = ROFF_LO + OFF_W;

  typedef logic [OFF_W-1:0] off_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_NUM_AXES     = 3'd0,
    REG_TARGET_SHAPE = 3'd1,
    REG_SOURCE_SHAPE = 3'd2,
    REG_ROW_MAJOR    = 3'd3,
    REG_ELEM_BYTES   = 3'd4,
    REG_PAD_VALUE    = 3'd5
  } cfg_reg_t;

  localparam logic [NAX_W-1:0] NUM_AXES_RST = 3'd1;
  localparam logic [CFG_W-1:0] SHAPE_RST    = 64'h0001_0001_0001_0001;
  localparam logic [EB_W-1:0]  EB_RST       = 4'd1;

endpackage

`default_nettype wire

FILE: src/nd_pad_reorder_address_gen_core.sv
// Accepted transactions pass stage 1, stage 2 and the output register to the master side.
// Throughput: one transaction per cycle unless stalled; s_tready follows m_tready.
// Stride setup: after reset and after every config write,
// serial stride multiplication (one multiply per stride line per cycle) holds s_tready low.
// Reset (rst, synchronous) restores config defaults, clears the odometer and empties the pipe.
// Depends on ndpr_pkg.
`default_nettype none

module nd_pad_reorder_address_gen_core #(
  parameter int MAX_AXES  = 4,
  parameter int AXIS_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // restart at bit 0
  input  wire  [ndpr_pkg::S_DATA_W-1:0]       s_tdata,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // write_offset [34:0], read_offset [69:35], fill_value [133:70]
  output logic [ndpr_pkg::M_DATA_W-1:0]       m_tdata,
  // inside_res
  output logic [ndpr_pkg::M_USER_W-1:0]       m_tuser,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  input  wire                                 cfg_we,
  input  wire  [ndpr_pkg::CIDX_W-1:0]         cfg_index,
  input  wire  [ndpr_pkg::CFG_W-1:0]          cfg_data
);

  localparam int EXT_W = ndpr_pkg::CFG_W + MAX_AXES * AXIS_BITS;
  localparam int CW    = $clog2(MAX_AXES + 1);
  localparam int IW    = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int OW    = ndpr_pkg::OFF_W;

  // configuration registers
  logic [ndpr_pkg::NAX_W-1:0] num_axes;
  logic [ndpr_pkg::CFG_W-1:0] target_shape_packed;
  logic [ndpr_pkg::CFG_W-1:0] source_shape_packed;
  logic                       output_row_major;
  logic [ndpr_pkg::EB_W-1:0]  element_bytes;
  logic [ndpr_pkg::CFG_W-1:0] pad_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_axes            <= ndpr_pkg::NUM_AXES_RST;
      target_shape_packed <= ndpr_pkg::SHAPE_RST;
      source_shape_packed <= ndpr_pkg::SHAPE_RST;
      output_row_major    <= 1'b1;
      element_bytes       <= ndpr_pkg::EB_RST;
      pad_value           <= '0;
    end else if (cfg_we) begin
      unique case (ndpr_pkg::cfg_reg_t'(cfg_index))
        ndpr_pkg::REG_NUM_AXES:     num_axes            <= cfg_data[ndpr_pkg::NAX_W-1:0];
        ndpr_pkg::REG_TARGET_SHAPE: target_shape_packed <= cfg_data;
        ndpr_pkg::REG_SOURCE_SHAPE: source_shape_packed <= cfg_data;
        ndpr_pkg::REG_ROW_MAJOR:    output_row_major    <= cfg_data[0];
        ndpr_pkg::REG_ELEM_BYTES:   element_bytes       <= cfg_data[ndpr_pkg::EB_W-1:0];
        ndpr_pkg::REG_PAD_VALUE:    pad_value           <= cfg_data;
        default: ;
      endcase
    end
  end

  // decoded extents, active mask, element size
  logic [EXT_W-1:0]     tgt_ext, src_ext;
  logic [AXIS_BITS-1:0] tgt_e [MAX_AXES];
  logic [AXIS_BITS-1:0] src_e [MAX_AXES];
  logic [MAX_AXES-1:0]  act;
  logic [MAX_AXES-1:0]  top_row;   // axis is the fastest active one in row-major order
  logic [ndpr_pkg::EB_W-1:0] eb;

  assign tgt_ext = EXT_W'(target_shape_packed);
  assign src_ext = EXT_W'(source_shape_packed);

  for (genvar g = 0; g < MAX_AXES; g++) begin : g_axis
    logic [AXIS_BITS-1:0] t_raw;
    assign t_raw    = tgt_ext[g*AXIS_BITS +: AXIS_BITS];
    assign tgt_e[g] = (t_raw == '0) ? AXIS_BITS'(1) : t_raw;
    assign src_e[g] = src_ext[g*AXIS_BITS +: AXIS_BITS];
    // axis 0 always active; zero axes counts as one
    assign act[g]   = (g == 0) || (int'(num_axes) > g);
    if (g == MAX_AXES - 1) begin : g_top
      assign top_row[g] = 1'b1;
    end else begin : g_mid
      assign top_row[g] = !act[g+1];
    end
  end

  always_comb begin
    if (element_bytes == '0) begin
      eb = ndpr_pkg::EB_W'(1);
    end else if (element_bytes > ndpr_pkg::EB_W'(ndpr_pkg::MAX_EB)) begin
      eb = ndpr_pkg::EB_W'(ndpr_pkg::MAX_EB);
    end else begin
      eb = element_bytes;
    end
  end

  // stride setup: three serial product chains, strides shifted into place
  logic              pend;
  logic [CW-1:0]     cnt;
  ndpr_pkg::off_t    run_c, run_s, run_r, v_r;
  ndpr_pkg::off_t    cw_str [MAX_AXES];
  ndpr_pkg::off_t    rw_str [MAX_AXES];
  ndpr_pkg::off_t    sr_str [MAX_AXES];
  logic [IW-1:0]     fidx, ridx;
  logic              setup_busy;

  assign fidx       = IW'(CW'(MAX_AXES) - cnt);
  assign ridx       = IW'(cnt - CW'(1));
  assign v_r        = top_row[ridx] ? OW'(eb) : run_r;
  assign setup_busy = pend || (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b1;
      cnt  <= '0;
    end else if (cfg_we) begin
      pend <= 1'b1;
      cnt  <= '0;
    end else if (pend) begin
      pend  <= 1'b0;
      cnt   <= CW'(MAX_AXES);
      run_c <= OW'(eb);
      run_s <= OW'(eb);
      run_r <= OW'(eb);
    end else if (cnt != '0) begin
      cnt   <= cnt - CW'(1);
      run_c <= OW'(run_c * tgt_e[fidx]);
      run_s <= OW'(run_s * src_e[fidx]);
      run_r <= OW'(v_r * tgt_e[ridx]);
      // forward chains fill from the top, backward chain from the bottom
      cw_str[MAX_AXES-1] <= run_c;
      sr_str[MAX_AXES-1] <= run_s;
      rw_str[0]          <= v_r;
      for (int k = 0; k < MAX_AXES - 1; k++) begin
        cw_str[k]   <= cw_str[k+1];
        sr_str[k]   <= sr_str[k+1];
        rw_str[k+1] <= rw_str[k];
      end
    end
  end

  // odometer
  logic [AXIS_BITS-1:0] pos     [MAX_AXES];
  logic [AXIS_BITS-1:0] cur     [MAX_AXES];
  logic [AXIS_BITS-1:0] pos_next[MAX_AXES];
  logic [MAX_AXES-1:0]  lt_src, at_end;
  logic [MAX_AXES:0]    carry;
  logic                 restart, cur_inside, cur_last;
  logic                 en, accept;

  assign restart = s_tdata[0];

  always_comb begin
    carry[0] = 1'b1;
    for (int k = 0; k < MAX_AXES; k++) begin
      cur[k]    = (restart || !act[k]) ? '0 : pos[k];
      lt_src[k] = cur[k] < src_e[k];
      at_end[k] = ({1'b0, cur[k]} + (AXIS_BITS+1)'(1)) >= {1'b0, tgt_e[k]};
      if (!act[k]) begin
        pos_next[k] = '0;
      end else if (carry[k]) begin
        pos_next[k] = at_end[k] ? '0 : cur[k] + AXIS_BITS'(1);
      end else begin
        pos_next[k] = cur[k];
      end
      carry[k+1] = carry[k] && at_end[k];
    end
    cur_inside = &(~act | lt_src);
    cur_last   = &(~act | at_end);
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !setup_busy;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_AXES; k++) pos[k] <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  // stage 1: position snapshot
  logic                 s1_valid, s1_inside, s1_last;
  logic [AXIS_BITS-1:0] s1_pos [MAX_AXES];
  // stage 2: per-axis products
  logic                 s2_valid, s2_inside, s2_last;
  ndpr_pkg::off_t       s2_pw [MAX_AXES];
  ndpr_pkg::off_t       s2_pr [MAX_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      m_tvalid <= s2_valid;
    end
  end

  ndpr_pkg::off_t woff_sum, roff_sum;
  logic [ndpr_pkg::FILL_W-1:0] fill_mask;

  always_comb begin
    woff_sum = '0;
    roff_sum = '0;
    for (int k = 0; k < MAX_AXES; k++) begin
      woff_sum = woff_sum + s2_pw[k];
      roff_sum = roff_sum + s2_pr[k];
    end
    for (int i = 0; i < ndpr_pkg::MAX_EB; i++) begin
      fill_mask[i*8 +: 8] = (i < int'(eb)) ? 8'hff : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pos    <= cur;
      s1_inside <= cur_inside;
      s1_last   <= cur_last;
      for (int k = 0; k < MAX_AXES; k++) begin
        s2_pw[k] <= OW'(s1_pos[k] * (output_row_major ? rw_str[k] : cw_str[k]));
        s2_pr[k] <= OW'(s1_pos[k] * sr_str[k]);
      end
      s2_inside <= s1_inside;
      s2_last   <= s1_last;
      m_tdata   <= {2'b00,
                    s2_inside ? '0 : (pad_value & fill_mask),
                    s2_inside ? roff_sum : '0,
                    woff_sum};
      m_tuser   <= s2_inside;
      m_tlast   <= s2_last;
    end
  end

endmodule

`default_nettype wire

FILE: src/ndpr_chk.sv
// Port-level checker for the N-d pad/reorder address generator, bound to the core.
// Depends on ndpr_pkg.
`default_nettype none

module ndpr_chk (
  input wire                           clk,
  input wire                           rst,
  input wire                           s_tready,
  input wire [ndpr_pkg::M_DATA_W-1:0]  m_tdata,
  input wire [ndpr_pkg::M_USER_W-1:0]  m_tuser,
  input wire                           m_tlast,
  input wire                           m_tvalid,
  input wire                           m_tready,
  input wire                           cfg_we
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("master transaction changed while stalled");

  // padded positions carry no source offset
  a_pad_roff: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |->
      m_tdata[ndpr_pkg::FILL_LO-1:ndpr_pkg::ROFF_LO] == '0)
    else $error("read offset nonzero on pad position");

  // copied positions carry no fill
  a_copy_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[ndpr_pkg::FILL_LO +: ndpr_pkg::FILL_W] == '0)
    else $error("fill value nonzero on copy position");

  // stride setup blocks input after reset and after every config write
  a_rst_setup: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted straight after reset");

  a_cfg_setup: assert property (@(posedge clk) disable iff (rst) cfg_we |=> !s_tready)
    else $error("input accepted straight after config write");

endmodule

bind nd_pad_reorder_address_gen_core ndpr_chk u_ndpr_chk (.*);

`default_nettype wire
